>>> design/dmpc_pkg.sv
`default_nettype none
package dmpc_pkg;

	// geometry of the cache
	localparam int SLOT_COUNT = 256;
	localparam int PAGE_WORDS = 512;
	localparam int ADDR_BITS  = 48;
	localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
	localparam int WORD_BITS  = $clog2(PAGE_WORDS);
	localparam int PAGE_SHIFT = 12;
	localparam int TAG_BITS   = 36;
	localparam int STORE_BITS = SLOT_BITS + WORD_BITS;
	localparam logic [47:0] ADDR_MASK =
		(ADDR_BITS >= 48) ? {48{1'b1}} : ((48'd1 << ADDR_BITS) - 48'd1);

	// command codes
	localparam logic [2:0] CMD_READ      = 3'd0;
	localparam logic [2:0] CMD_WRITE     = 3'd1;
	localparam logic [2:0] CMD_INVAL     = 3'd2;
	localparam logic [2:0] CMD_FLUSH     = 3'd3;
	localparam logic [2:0] CMD_FILL      = 3'd4;
	localparam logic [2:0] CMD_FILL_ERR  = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_MISS       = 2'd1;
	localparam logic [1:0] ST_PROVIDER   = 2'd2;
	localparam logic [1:0] ST_BACKING    = 2'd3;

	typedef struct packed {
		logic [2:0]  command;
		logic [47:0] address;
		logic [31:0] length;
		logic [63:0] write_data;
		logic        backing_ok;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] read_data;
		logic [35:0] fill_page;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_FILL_RD,
		S_FILL_OUT,
		S_WALK,
		S_CLEAR
	} state_t;

endpackage
`default_nettype wire

>>> design/direct_mapped_page_cache_top.sv
`default_nettype none
// early answers (zero length, no backing, refused write, flush, fill error) skip lookup;
// read and write pass through lookup (tag and word read, then compare and write back), and
// the last fill word through fill read and fill out. items are taken only while idle;
// invalidate range walks every tag (one tag a cycle) and flush clears every tag, under busy.
// reset clears counters and fill state at once, then busy stays high while the tag store
// is cleared; the page store is not cleared. results last one cycle; no receiver stall.
module direct_mapped_page_cache_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire dmpc_pkg::req_t req,
	output logic                done,
	output dmpc_pkg::rsp_t      rsp,
	input  wire logic           cfg_we,
	input  wire logic           cfg_wdata
);
	import dmpc_pkg::*;

	state_t state_q, state_d;

	logic                  backing_q;
	logic [31:0]           hit_q, miss_q;
	logic                  fill_pending_q;
	logic [WORD_BITS-1:0]  fill_idx_q;
	logic [TAG_BITS-1:0]   pend_page_q;
	logic [WORD_BITS-1:0]  pend_word_q;
	logic                  done_q;
	rsp_t                  rsp_q;

	// per-access registers
	logic [2:0]           op_s1;
	logic [SLOT_BITS-1:0] slot_s1;
	logic [WORD_BITS-1:0] word_s1;
	logic [TAG_BITS-1:0]  page_s1;
	logic [63:0]          mask_s1;
	logic [63:0]          wdata_s1;
	logic [TAG_BITS-1:0]  first_s1, last_s1;
	logic [SLOT_BITS:0]   walk_q;
	logic                 cmp_v_s1;
	logic [SLOT_BITS-1:0] cmp_idx_s1;

	// memories; a tag entry holds its valid bit on top
	logic [63:0]         store [(1 << STORE_BITS)];
	logic [TAG_BITS:0]   tags  [SLOT_COUNT];
	logic [63:0]         st_rdata;
	logic [TAG_BITS:0]   tag_rdata;
	logic                tag_valid;
	logic [TAG_BITS-1:0] tag_page;

	assign tag_valid = tag_rdata[TAG_BITS];
	assign tag_page  = tag_rdata[TAG_BITS-1:0];

	// decode of the incoming item
	logic                 accept;
	logic [47:0]          addr_m;
	logic [TAG_BITS-1:0]  page_in;
	logic [SLOT_BITS-1:0] slot_in;
	logic [WORD_BITS-1:0] word_in;
	logic [SLOT_BITS-1:0] pslot;
	logic [47:0]          end_addr;
	logic [3:0]           lenc, room, nbytes;
	logic [63:0]          mask_in;
	logic                 len_zero, last_fill;

	assign accept   = start && (state_q == S_IDLE);
	assign addr_m   = req.address & ADDR_MASK;
	assign page_in  = addr_m[47:PAGE_SHIFT];
	assign slot_in  = page_in[SLOT_BITS-1:0];
	assign word_in  = addr_m[PAGE_SHIFT-1:3];
	assign pslot    = pend_page_q[SLOT_BITS-1:0];
	assign len_zero = (req.length == 32'd0);
	assign end_addr = (addr_m + {16'd0, req.length} - 48'd1) & ADDR_MASK;
	assign last_fill = (fill_idx_q == WORD_BITS'(PAGE_WORDS - 1));

	// byte lanes of a write
	always_comb begin
		lenc   = (req.length >= 32'd8) ? 4'd8 : req.length[3:0];
		room   = 4'd8 - {1'b0, addr_m[2:0]};
		nbytes = (lenc < room) ? lenc : room;
		for (int b = 0; b < 8; b++) begin
			mask_in[b*8 +: 8] = ((4'(b) >= {1'b0, addr_m[2:0]}) &&
				(4'(b) < {1'b0, addr_m[2:0]} + nbytes)) ? 8'hFF : 8'h00;
		end
	end

	// lookup result
	logic        hit_s1;
	logic [63:0] merged;
	logic        in_range;
	assign hit_s1 = tag_valid && (tag_page == page_s1);
	assign merged = (st_rdata & ~mask_s1) | (wdata_s1 & mask_s1);
	assign in_range = (first_s1 <= last_s1) ?
		((tag_page >= first_s1) && (tag_page <= last_s1)) :
		((tag_page >= first_s1) || (tag_page <= last_s1));

	// memory port control
	logic                  st_we;
	logic [STORE_BITS-1:0] st_waddr, st_raddr;
	logic [63:0]           st_wdata;
	logic                  tag_we;
	logic [SLOT_BITS-1:0]  tag_waddr, tag_raddr;
	logic [TAG_BITS:0]     tag_wdata;

	always_comb begin
		st_we     = 1'b0;
		st_waddr  = {slot_s1, word_s1};
		st_wdata  = merged;
		st_raddr  = {slot_in, word_in};
		tag_we    = 1'b0;
		tag_waddr = slot_s1;
		tag_wdata = {1'b0, tag_page};
		tag_raddr = slot_in;
		case (state_q)
			S_IDLE: begin
				if (accept && req.command == CMD_FILL && fill_pending_q) begin
					st_we     = 1'b1;
					st_waddr  = {pslot, fill_idx_q};
					st_wdata  = req.write_data;
					tag_we    = last_fill;
					tag_waddr = pslot;
					tag_wdata = {1'b1, pend_page_q};
				end
				if (accept && req.command == CMD_FILL_ERR && fill_pending_q) begin
					tag_we    = 1'b1;
					tag_waddr = pslot;
					tag_wdata = {1'b0, pend_page_q};
				end
			end
			S_LOOKUP: begin
				st_we  = (op_s1 == CMD_WRITE) && hit_s1;
				tag_we = (op_s1 == CMD_READ) && !hit_s1;
			end
			S_FILL_RD: begin
				st_raddr = {pslot, pend_word_q};
			end
			S_WALK: begin
				tag_raddr = walk_q[SLOT_BITS-1:0];
				tag_we    = cmp_v_s1 && tag_valid && in_range;
				tag_waddr = cmp_idx_s1;
			end
			S_CLEAR: begin
				tag_we    = 1'b1;
				tag_waddr = walk_q[SLOT_BITS-1:0];
				tag_wdata = '0;
			end
			default: begin
			end
		endcase
	end

	// page store
	always_ff @(posedge clk) begin
		if (st_we) begin
			store[st_waddr] <= st_wdata;
		end
		st_rdata <= store[st_raddr];
	end

	// tag store
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tags[tag_waddr] <= tag_wdata;
		end
		tag_rdata <= tags[tag_raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.command)
						CMD_READ:  if (!len_zero && backing_q) state_d = S_LOOKUP;
						CMD_WRITE: if (!len_zero && backing_q && req.backing_ok)
							state_d = S_LOOKUP;
						CMD_INVAL: if (!len_zero) state_d = S_WALK;
						CMD_FLUSH: state_d = S_CLEAR;
						CMD_FILL:  if (fill_pending_q && last_fill) state_d = S_FILL_RD;
						default: begin
						end
					endcase
				end
			end
			S_LOOKUP:   state_d = S_IDLE;
			S_FILL_RD:  state_d = S_FILL_OUT;
			S_FILL_OUT: state_d = S_IDLE;
			S_WALK: begin
				if (cmp_v_s1 && cmp_idx_s1 == SLOT_BITS'(SLOT_COUNT - 1)) state_d = S_IDLE;
			end
			S_CLEAR: begin
				if (walk_q[SLOT_BITS-1:0] == SLOT_BITS'(SLOT_COUNT - 1)) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		busy = (state_q != S_IDLE);
		done = done_q;
		rsp  = rsp_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			backing_q      <= 1'b1;
			hit_q          <= '0;
			miss_q         <= '0;
			fill_pending_q <= 1'b0;
			fill_idx_q     <= '0;
			pend_page_q    <= '0;
			pend_word_q    <= '0;
			done_q         <= 1'b0;
			walk_q         <= '0;
			cmp_v_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_we) begin
				backing_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.command <= CMD_FLUSH) begin
							fill_pending_q <= 1'b0;
							fill_idx_q     <= '0;
						end
						case (req.command)
							CMD_READ, CMD_WRITE: begin
								done_q <= len_zero || !backing_q ||
									(req.command == CMD_WRITE && !req.backing_ok);
							end
							CMD_INVAL: begin
								done_q <= len_zero;
								walk_q <= '0;
							end
							CMD_FLUSH: begin
								done_q <= 1'b1;
								walk_q <= '0;
							end
							CMD_FILL: begin
								if (fill_pending_q) begin
									if (last_fill) begin
										fill_pending_q <= 1'b0;
										fill_idx_q     <= '0;
									end else begin
										fill_idx_q <= fill_idx_q + 1'b1;
									end
								end
							end
							CMD_FILL_ERR: begin
								if (fill_pending_q) begin
									fill_pending_q <= 1'b0;
									fill_idx_q     <= '0;
									done_q         <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_LOOKUP: begin
					done_q <= 1'b1;
					if (op_s1 == CMD_READ) begin
						if (hit_s1) begin
							hit_q <= hit_q + 32'd1;
						end else begin
							miss_q          <= miss_q + 32'd1;
							fill_pending_q  <= 1'b1;
							fill_idx_q      <= '0;
							pend_page_q     <= page_s1;
							pend_word_q     <= word_s1;
						end
					end
				end
				S_FILL_OUT: begin
					done_q <= 1'b1;
				end
				S_WALK: begin
					cmp_v_s1 <= !walk_q[SLOT_BITS];
					if (!walk_q[SLOT_BITS]) begin
						walk_q <= walk_q + 1'b1;
					end
					if (cmp_v_s1 && cmp_idx_s1 == SLOT_BITS'(SLOT_COUNT - 1)) begin
						done_q <= 1'b1;
					end
				end
				S_CLEAR: begin
					walk_q <= walk_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= walk_q[SLOT_BITS-1:0];
		if (accept) begin
			op_s1    <= req.command;
			slot_s1  <= slot_in;
			word_s1  <= word_in;
			page_s1  <= page_in;
			mask_s1  <= mask_in;
			wdata_s1 <= req.write_data;
			first_s1 <= page_in;
			last_s1  <= end_addr[47:PAGE_SHIFT];
			rsp_q.status     <= ST_OK;
			rsp_q.read_data  <= '0;
			rsp_q.fill_page  <= '0;
			rsp_q.hit_total  <= hit_q;
			rsp_q.miss_total <= miss_q;
			if ((req.command == CMD_READ || req.command == CMD_WRITE) && !len_zero) begin
				if (!backing_q) begin
					rsp_q.status <= ST_PROVIDER;
				end else if (req.command == CMD_WRITE && !req.backing_ok) begin
					rsp_q.status <= ST_BACKING;
				end
			end
			if (req.command == CMD_FILL_ERR) begin
				rsp_q.status <= ST_BACKING;
			end
		end
		if (state_q == S_LOOKUP && op_s1 == CMD_READ) begin
			if (hit_s1) begin
				rsp_q.read_data <= st_rdata;
				rsp_q.hit_total <= hit_q + 32'd1;
			end else begin
				rsp_q.status     <= ST_MISS;
				rsp_q.fill_page  <= page_s1;
				rsp_q.miss_total <= miss_q + 32'd1;
			end
		end
		if (state_q == S_FILL_OUT) begin
			rsp_q.read_data <= st_rdata;
		end
	end

	// checks
	a_walk_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> !done_q)
		else $error("result during invalidate walk");
	a_miss_pends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOKUP && op_s1 == CMD_READ && !hit_s1) |=> fill_pending_q)
		else $error("read miss did not start a fill");
	a_fill_closed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL_RD |-> !fill_pending_q)
		else $error("fill completion left state open");
	a_lookup_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOOKUP |=> done_q && state_q == S_IDLE)
		else $error("lookup gave no result");

endmodule
`default_nettype wire
